// ===== rtl/core/bayer_rggb_demosaic_macros.svh =====
// Assertion helpers shared by the demosaic RTL.
// Every check is sampled on the rising edge of clk and is off while rst is high.
`ifndef BAYER_RGGB_DEMOSAIC_MACROS_SVH
`define BAYER_RGGB_DEMOSAIC_MACROS_SVH

// A property that must hold at every clock edge.
`define BDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define BDM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/bdm_pkg.sv =====
`timescale 1ns / 1ps

package bdm_pkg;

  // Sizing of the line stores and the sample path.
  localparam int MAX_WIDTH   = 2048;
  localparam int SAMPLE_BITS = 10;
  localparam int MAX_HEIGHT  = 4096;

  // Fixed field widths of the ports.
  localparam int RAW_W      = 16;
  localparam int CHAN_W     = 8;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Derived widths.
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);

  // Job queue between the front and the back. The depth is a power of two.
  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd1920;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_index_t;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // 3x3 neighborhood, indexed [row][column]; row 0 is the top, column 0 the oldest.
  typedef logic [2:0][2:0][SAMPLE_BITS-1:0] window_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_sample;
    logic             drain;
  } raw_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              end_of_row;
    logic              end_of_frame;
  } pixel_t;

  // Classification of one window: which sites it yields and their edge flags.
  // Site A is the column left of the newest one, site B the newest column.
  typedef struct packed {
    logic emit_a;
    logic emit_b;
    logic a_last;
    logic a_left;
    logic b_left;
    logic c_odd;
    logic y_odd;
    logic top;
    logic bottom;
  } job_info_t;

  typedef struct packed {
    window_t   win;
    job_info_t info;
  } job_t;

  typedef struct packed {
    logic                 empty;
    logic [JOB_CNT_W-1:0] count;
  } job_status_t;

  // Truncating mean of two samples.
  function automatic sample_t avg2(sample_t a, sample_t b);
    logic [SAMPLE_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[SAMPLE_BITS:1];
  endfunction

  // Top eight bits of a sample form one output channel.
  function automatic logic [CHAN_W-1:0] chan(sample_t v);
    return v[SAMPLE_BITS-1 -: CHAN_W];
  endfunction

endpackage

// ===== rtl/core/bdm_ram.sv =====
`timescale 1ns / 1ps

module bdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bdm_front.sv =====
`timescale 1ns / 1ps
`include "bayer_rggb_demosaic_macros.svh"

module bdm_front import bdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  raw_t                  raw,
  output logic                  full,
  output logic                  job_push,
  output job_t                  job,
  input  job_status_t           jstat
);

  logic [FW_W-1:0]   frame_width;
  logic [FH_W-1:0]   frame_height;
  logic [WCNT_W-1:0] eff_w;
  logic [ROW_W-1:0]  eff_h;

  logic [ADDR_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0]  row_count, row_count_next;

  logic             accept, load, in_frame, row_last, has_row;
  logic [ROW_W-1:0] site_row;
  sample_t          sample_in;
  job_info_t        info_in;

  // Second stage: one request whose line-store read is in flight.
  logic              s1_valid;
  logic              s1_write;
  logic [ADDR_W-1:0] s1_idx;
  sample_t           s1_sample;
  job_info_t         s1_info;

  // Bypass for a read that met the write of the same entry.
  logic    fwd_hit;
  sample_t fwd_up, fwd_mid;

  sample_t up_rd, mid_rd, top_in, mid_in;
  window_t win, win_next;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, large values saturate.
  always_comb begin
    if (frame_width == '0) begin
      eff_w = WCNT_W'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = WCNT_W'(MAX_WIDTH);
    end else begin
      eff_w = WCNT_W'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = ROW_W'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end else begin
      eff_h = ROW_W'(frame_height);
    end
  end

  // Leave room in the job queue for the request already in the second stage.
  assign full = ({1'b0, jstat.count} + (JOB_CNT_W + 1)'(s1_valid))
                >= (JOB_CNT_W + 1)'(JOB_DEPTH);
  assign accept = push && !full;

  // Classify the request: samples count during the frame, drains after it.
  always_comb begin
    in_frame  = 32'(row_count) < 32'(eff_h);
    row_last  = (32'(column_count) + 32'd1) >= 32'(eff_w);
    load      = accept && (in_frame ? !raw.drain : raw.drain);
    has_row   = in_frame ? (row_count != '0) : 1'b1;
    site_row  = in_frame ? (row_count - ROW_W'(1)) : (eff_h - ROW_W'(1));
    sample_in = in_frame ? raw.raw_sample[SAMPLE_BITS-1:0] : '0;

    info_in.emit_a = has_row && (column_count != '0);
    info_in.emit_b = has_row && row_last;
    info_in.a_last = 32'(column_count) >= 32'(eff_w);
    info_in.a_left = column_count == ADDR_W'(1);
    info_in.b_left = column_count == '0;
    info_in.c_odd  = column_count[0];
    info_in.y_odd  = site_row[0];
    info_in.top    = site_row == '0;
    info_in.bottom = (32'(site_row) + 32'd1) >= 32'(eff_h);
  end

  // Raster position; the drain phase ends the frame and restarts at the origin.
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (load) begin
      if (row_last) begin
        column_count_next = '0;
        row_count_next    = in_frame ? (row_count + ROW_W'(1)) : '0;
      end else begin
        column_count_next = column_count + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Load the second stage and note a bypass when the read hits the entry
  // that the stage is writing at the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      s1_valid <= load;
      fwd_hit  <= load && s1_valid && s1_write && (s1_idx == column_count);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_write  <= in_frame;
      s1_idx    <= column_count;
      s1_sample <= sample_in;
      s1_info   <= info_in;
    end
    fwd_up  <= mid_in;
    fwd_mid <= s1_sample;
  end

  // Line stores: the upper row takes the old middle row, the middle row the new sample.
  bdm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_upper_line (
    .clk   (clk),
    .we    (s1_valid && s1_write),
    .waddr (s1_idx),
    .wdata (mid_in),
    .re    (load),
    .raddr (column_count),
    .rdata (up_rd)
  );

  bdm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_middle_line (
    .clk   (clk),
    .we    (s1_valid && s1_write),
    .waddr (s1_idx),
    .wdata (s1_sample),
    .re    (load),
    .raddr (column_count),
    .rdata (mid_rd)
  );

  assign top_in = fwd_hit ? fwd_up : up_rd;
  assign mid_in = fwd_hit ? fwd_mid : mid_rd;

  // Shift the new column into the window.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r][0] = win[r][1];
      win_next[r][1] = win[r][2];
    end
    win_next[0][2] = top_in;
    win_next[1][2] = mid_in;
    win_next[2][2] = s1_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  // Hand a window to the back only when it yields at least one pixel.
  assign job_push = s1_valid && (s1_info.emit_a || s1_info.emit_b);
  assign job.win  = win_next;
  assign job.info = s1_info;

  `BDM_ASSERT_IMPL(a_fwd_with_item, fwd_hit, s1_valid, "bypass set without a request in stage two")
  `BDM_ASSERT_IMPL(a_write_in_frame, job_push && s1_write, !s1_info.bottom, "bottom site in frame")

endmodule

// ===== rtl/core/bdm_job_fifo.sv =====
`timescale 1ns / 1ps
`include "bayer_rggb_demosaic_macros.svh"

module bdm_job_fifo import bdm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  job_t        wdata,
  input  logic        pop,
  output job_t        rdata,
  output job_status_t status
);

  localparam logic [JOB_CNT_W-1:0] FULL_COUNT = JOB_CNT_W'(JOB_DEPTH);

  job_t                 mem [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wptr, rptr;
  logic [JOB_CNT_W-1:0] count;

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + JOB_PTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + JOB_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + JOB_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - JOB_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  assign rdata        = mem[rptr];
  assign status.empty = count == '0;
  assign status.count = count;

  `BDM_ASSERT_IMPL(a_no_overflow, push && !pop, count != FULL_COUNT, "job queue overflow")
  `BDM_ASSERT_IMPL(a_no_underflow, pop, count != '0, "job queue underflow")

endmodule

// ===== rtl/core/bdm_back.sv =====
`timescale 1ns / 1ps
`include "bayer_rggb_demosaic_macros.svh"

module bdm_back import bdm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  job_status_t jstat,
  input  job_t        job,
  output logic        job_pop,
  output logic        empty,
  input  logic        pop,
  output pixel_t      pixel
);

  // Set while the head window has given its first site and still owes the second.
  logic phase;

  logic    advance, take, use_b, last, left, x_odd, two_site_head;
  window_t h_win, v_win;
  sample_t r_val, g_val, b_val;
  pixel_t  res;

  logic   out_valid;
  pixel_t out_pix;

  assign advance = !out_valid || pop;
  assign take    = !jstat.empty && advance;
  assign use_b   = !job.info.emit_a || phase;
  assign job_pop = take && (use_b || !job.info.emit_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (take) begin
      phase <= !use_b && job.info.emit_b;
    end
  end

  // Edge flags of the site being produced.
  assign last  = use_b ? 1'b1 : job.info.a_last;
  assign left  = use_b ? job.info.b_left : job.info.a_left;
  assign x_odd = use_b ? job.info.c_odd : !job.info.c_odd;

  // Pick the three columns and apply the left and right edge substitutions.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      h_win[r][0] = use_b ? job.win[r][1] : job.win[r][0];
      h_win[r][1] = use_b ? job.win[r][2] : job.win[r][1];
      h_win[r][2] = job.win[r][2];
      if (last) begin
        h_win[r][2] = left ? h_win[r][1] : h_win[r][0];
      end
      if (left) begin
        h_win[r][0] = h_win[r][2];
      end
    end
  end

  // Top and bottom edge substitutions.
  always_comb begin
    v_win[1] = h_win[1];
    v_win[2] = h_win[2];
    if (job.info.bottom) begin
      v_win[2] = job.info.top ? h_win[1] : h_win[0];
    end
    v_win[0] = job.info.top ? v_win[2] : h_win[0];
  end

  // Bilinear interpolation by color phase of the site.
  always_comb begin
    if (!job.info.y_odd) begin
      if (!x_odd) begin
        r_val = v_win[1][1];
        g_val = avg2(v_win[1][2], v_win[2][1]);
        b_val = v_win[2][2];
      end else begin
        r_val = avg2(v_win[1][0], v_win[1][2]);
        g_val = v_win[1][1];
        b_val = avg2(v_win[2][0], v_win[2][2]);
      end
    end else begin
      if (!x_odd) begin
        r_val = avg2(v_win[0][1], v_win[2][1]);
        g_val = v_win[1][1];
        b_val = avg2(v_win[1][0], v_win[1][2]);
      end else begin
        r_val = v_win[0][2];
        g_val = avg2(v_win[0][1], v_win[1][2]);
        b_val = v_win[1][1];
      end
    end
    res.red          = chan(r_val);
    res.green        = chan(g_val);
    res.blue         = chan(b_val);
    res.end_of_row   = last;
    res.end_of_frame = last && job.info.bottom;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_pix <= res;
    end
  end

  assign empty = !out_valid;
  assign pixel = out_pix;

  // A pending second site needs a two-site window at the queue head.
  assign two_site_head = !jstat.empty && job.info.emit_a && job.info.emit_b;

  `BDM_ASSERT_IMPL(a_phase_head, phase, two_site_head, "second site pending without a two-site head")

endmodule

// ===== rtl/core/bayer_rggb_demosaic.sv =====
// A completed pixel passes the second-stage register, the job queue and the output register.
// Throughput: one request per cycle while full is low, set by the single read and write
// port of each line store. The last site of a row is a second pixel of the same request;
// the next row's first request yields none when the frame is wider than one column.
// Reset: rst is synchronous; it clears the counters, window, job queue and output valid
// and sets 1920x1080. The line stores are not cleared; no clearing pass runs after reset.
`timescale 1ns / 1ps

module bayer_rggb_demosaic import bdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  raw_t                  raw,
  output logic                  empty,
  input  logic                  pop,
  output pixel_t                pixel
);

  logic        job_push, job_pop;
  job_t        job_in, job_head;
  job_status_t jstat;

  // Front: raster counters, line stores and window.
  bdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .raw       (raw),
    .full      (full),
    .job_push  (job_push),
    .job       (job_in),
    .jstat     (jstat)
  );

  // Queue of classified windows.
  bdm_job_fifo u_job_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wdata  (job_in),
    .pop    (job_pop),
    .rdata  (job_head),
    .status (jstat)
  );

  // Back: interpolation and result register.
  bdm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .jstat   (jstat),
    .job     (job_head),
    .job_pop (job_pop),
    .empty   (empty),
    .pop     (pop),
    .pixel   (pixel)
  );

endmodule

// ===== bench/demosaic_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration, raw and pixel channels of the demosaic block, keeps its own
// model of the line stores and the 3x3 window, and compares every popped pixel with the
// oldest predicted one.
module demosaic_checker import bdm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  logic                  full,
  input  raw_t                  raw,
  input  logic                  empty,
  input  logic                  pop,
  input  pixel_t                pixel,
  output int                    mismatches,
  output int                    outstanding
);

  // Model state: two previous rows, the window [row][column] and the raster position.
  sample_t         upper_row [MAX_WIDTH];
  sample_t         middle_row [MAX_WIDTH];
  sample_t         win [3][3];
  int unsigned     col_pos;
  int unsigned     row_pos;
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;

  pixel_t expected_pixels [$];
  int     error_count = 0;
  int     pixels_seen = 0;

  assign mismatches = error_count;

  // A width of zero acts as one; anything above the line store size saturates.
  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  // Move the window one column left and bring in a new column on the right.
  function automatic void shift_column(sample_t top, sample_t mid, sample_t bot);
    int r;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;
  endfunction

  // Bilinear RGGB interpolation of site (x, y); ctr is the window column holding the site.
  function automatic pixel_t demosaic_site(int unsigned x, int unsigned y, int unsigned w,
                                           int unsigned h, int ctr);
    logic [SAMPLE_BITS:0] v [3][3];
    logic [SAMPLE_BITS:0] r, g, b;
    logic                 last, bottom;
    pixel_t               pix;
    int                   i;
    last   = (x + 1 >= w);
    bottom = (y + 1 >= h);
    // Horizontal edges: the left neighbor mirrors to the right one and vice versa.
    for (i = 0; i < 3; i++) begin
      v[i][0] = win[i][ctr-1];
      v[i][1] = win[i][ctr];
      if (ctr < 2) v[i][2] = win[i][ctr+1];
      else v[i][2] = v[i][1];
      if (last) v[i][2] = (x == 0) ? v[i][1] : v[i][0];
      if (x == 0) v[i][0] = v[i][2];
    end
    // Vertical edges: the row above stands in below at the bottom, and the reverse at the top.
    for (i = 0; i < 3; i++) begin
      if (bottom) v[2][i] = (y == 0) ? v[1][i] : v[0][i];
      if (y == 0) v[0][i] = v[2][i];
    end
    if ((y & 1) == 0) begin
      if ((x & 1) == 0) begin
        r = v[1][1];
        g = (v[1][2] + v[2][1]) >> 1;
        b = v[2][2];
      end else begin
        r = (v[1][0] + v[1][2]) >> 1;
        g = v[1][1];
        b = (v[2][0] + v[2][2]) >> 1;
      end
    end else begin
      if ((x & 1) == 0) begin
        r = (v[0][1] + v[2][1]) >> 1;
        g = v[1][1];
        b = (v[1][0] + v[1][2]) >> 1;
      end else begin
        r = v[0][2];
        g = (v[0][1] + v[1][2]) >> 1;
        b = v[1][1];
      end
    end
    pix.red          = CHAN_W'(r >> (SAMPLE_BITS - CHAN_W));
    pix.green        = CHAN_W'(g >> (SAMPLE_BITS - CHAN_W));
    pix.blue         = CHAN_W'(b >> (SAMPLE_BITS - CHAN_W));
    pix.end_of_row   = last;
    pix.end_of_frame = last && bottom;
    return pix;
  endfunction

  // Apply one accepted raw request and queue the pixels it completes.
  task automatic advance_stream(input raw_t item);
    int unsigned w, h, c, y, idx;
    sample_t     s;
    w   = active_width();
    h   = active_height();
    c   = col_pos;
    y   = row_pos;
    idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    s   = item.raw_sample[SAMPLE_BITS-1:0];
    if (y < h) begin
      // Frame phase: drains are ignored.
      if (item.drain) return;
      shift_column(upper_row[idx], middle_row[idx], s);
      upper_row[idx]  = middle_row[idx];
      middle_row[idx] = s;
      if (y >= 1) begin
        if (c >= 1) expected_pixels.push_back(demosaic_site(c - 1, y - 1, w, h, 1));
        if (c + 1 >= w) expected_pixels.push_back(demosaic_site(c, y - 1, w, h, 2));
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = y + 1;
      end else begin
        col_pos = c + 1;
      end
    end else begin
      // Drain phase: samples are ignored, drains flush the final row.
      if (!item.drain) return;
      shift_column(upper_row[idx], middle_row[idx], '0);
      if (c >= 1) expected_pixels.push_back(demosaic_site(c - 1, h - 1, w, h, 1));
      if (c + 1 >= w) begin
        expected_pixels.push_back(demosaic_site(c, h - 1, w, h, 2));
        col_pos = 0;
        row_pos = 0;
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  // Print one line per mismatch (the first hundred) and count all of them.
  task automatic report_mismatch(input string what);
    if (error_count < 100) $display("%0t ns: pixel %0d: %s", $time, pixels_seen, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [CHAN_W-1:0] got,
                             input logic [CHAN_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Outputs are compared before inputs are applied: no pixel can leave in the cycle
  // its request is taken.
  always @(posedge clk) begin
    pixel_t want;
    int     k;
    if (rst) begin
      for (k = 0; k < MAX_WIDTH; k++) begin
        upper_row[k]  = '0;
        middle_row[k] = '0;
      end
      win        = '{default: '0};
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      expected_pixels.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixel popped with nothing expected");
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", pixel.red, want.red);
          check_field("green", pixel.green, want.green);
          check_field("blue", pixel.blue, want.blue);
          check_field("end_of_row", CHAN_W'(pixel.end_of_row), CHAN_W'(want.end_of_row));
          check_field("end_of_frame", CHAN_W'(pixel.end_of_frame),
                      CHAN_W'(want.end_of_frame));
        end
        pixels_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FRAME_WIDTH: begin
            width_reg = cfg_data[FW_W-1:0];
          end
          CFG_FRAME_HEIGHT: begin
            height_reg = cfg_data[FH_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (push && !full) advance_stream(raw);
    end
    outstanding <= expected_pixels.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bdm_pkg::*;

  // Register indexes that decode to nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_HI = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  push      = 1'b0;
  logic                  full;
  raw_t                  raw       = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  pixel_t                pixel;

  int mismatches;
  int outstanding;

  int send_idle_pct = 32;
  int recv_idle_pct = 80;
  int items_sent    = 0;
  int frame_cols    = 1;
  int frame_rows    = 1;
  int target;

  always #5 clk = ~clk;

  bayer_rggb_demosaic DUT (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .push, .full, .raw, .empty, .pop, .pixel
  );

  demosaic_checker pixel_check (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .push, .full, .raw, .empty, .pop, .pixel, .mismatches, .outstanding
  );

  // The receiver stalls at random.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one raw request after a random gap and hold it until it is taken.
  task automatic send_raw(input logic [RAW_W-1:0] word, input logic is_drain);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    raw  <= raw_t'{raw_sample: word, drain: is_drain};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Stop pushing, let every predicted pixel drain out, then give the pipeline time to settle.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int clamp_size(input int value, input int limit);
    if (value == 0) return 1;
    if (value > limit) return limit;
    return value;
  endfunction

  // Reconfigure between frames, sometimes touching an unused index first.
  task automatic set_frame(input logic [CFG_DATA_W-1:0] data_w,
                           input logic [CFG_DATA_W-1:0] data_h);
    wait_idle();
    if ($urandom_range(9) == 0)
      write_reg($urandom_range(1) ? CFG_RESERVED_HI : CFG_RESERVED_LO,
                CFG_DATA_W'($urandom_range(8191)));
    write_reg(CFG_FRAME_WIDTH, data_w);
    write_reg(CFG_FRAME_HEIGHT, data_h);
    cfg_valid  <= 1'b0;
    frame_cols = clamp_size(int'(data_w[FW_W-1:0]), MAX_WIDTH);
    frame_rows = clamp_size(int'(data_h), MAX_HEIGHT);
  endtask

  function automatic logic [RAW_W-1:0] random_word();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'h03FF;
      2: return '1;
      default: return RAW_W'($urandom_range(65535));
    endcase
  endfunction

  // One well-formed frame plus its drain row, with stray requests mixed in at noise_pct.
  task automatic run_frame(input int noise_pct);
    int r, c;
    for (r = 0; r < frame_rows; r++) begin
      for (c = 0; c < frame_cols; c++) begin
        if ($urandom_range(99) < noise_pct) send_raw(random_word(), 1'b1);
        send_raw(random_word(), 1'b0);
        items_sent++;
      end
    end
    for (c = 0; c < frame_cols; c++) begin
      if ($urandom_range(99) < noise_pct) send_raw(random_word(), 1'b0);
      send_raw(random_word(), 1'b1);
      items_sent++;
    end
  endtask

  // Mostly small frames, with degenerate one-pixel rows and one-row frames now and then.
  task automatic random_frame(input int noise_pct);
    int pick, w, h;
    pick = $urandom_range(99);
    if (pick < 8) w = $urandom_range(1);
    else if (pick < 80) w = $urandom_range(8, 2);
    else w = $urandom_range(40, 9);
    h = ($urandom_range(99) < 8) ? $urandom_range(1) : $urandom_range(6, 2);
    set_frame({1'($urandom_range(1)), FW_W'(w)}, CFG_DATA_W'(h));
    run_frame(noise_pct);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Two by two frame: sample extremes, unused high bits, a stray drain inside the
    // frame and a stray sample inside the drain row.
    set_frame(13'd2, 13'd2);
    send_raw(16'h03FF, 1'b0);
    send_raw(16'h0000, 1'b1);
    send_raw(16'h0000, 1'b0);
    send_raw(16'hFFFF, 1'b0);
    send_raw(16'hFC00, 1'b0);
    send_raw(16'h0001, 1'b1);
    send_raw(16'h03FF, 1'b0);
    send_raw(16'hFFFF, 1'b1);

    // Width zero with bit 12 set: one-pixel rows, both edges on the same column.
    set_frame(13'h1000, 13'd3);
    send_raw(16'h03FF, 1'b0);
    send_raw(16'h0155, 1'b0);
    send_raw(16'h02AA, 1'b0);
    send_raw(16'h0000, 1'b1);

    // Height zero: a single row that is top and bottom at once.
    set_frame(13'd3, 13'd0);
    send_raw(16'hFFFF, 1'b0);
    send_raw(16'h0001, 1'b0);
    send_raw(16'h0200, 1'b0);
    repeat (3) send_raw(16'h0000, 1'b1);

    // Sender idles lightly, receiver heavily.
    target = items_sent + 370;
    while (items_sent < target) random_frame(5);

    // Sender idles heavily, receiver lightly.
    wait_idle();
    send_idle_pct = 80;
    recv_idle_pct = 32;
    target = items_sent + 370;
    while (items_sent < target) random_frame(5);

    // No idling on either side, ending with a width write that carries an unused high bit.
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    target = items_sent + 370;
    while (items_sent < target) random_frame(5);
    set_frame(13'h1002, 13'd3);
    run_frame(1);

    wait_idle();
    if (mismatches == 0) begin
      $display("bayer_rggb_demosaic verification clean");
    end else begin
      $display("bayer_rggb_demosaic verification failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("bayer_rggb_demosaic verification failed");
    $finish;
  end

endmodule
